[sv/kway_merge_dedup_assert.svh]
// assertion macros shared by the merge block checks
`ifndef KWAY_MERGE_DEDUP_ASSERT_SVH
`define KWAY_MERGE_DEDUP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define KMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kway_merge_dedup check failed");

// next-cycle implication, disabled while reset is high
`define KMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kway_merge_dedup check failed");

`endif

[sv/kmd_pkg.sv]
// shared widths, result codes and defaults of the k-way merge block
package kmd_pkg;

   localparam int MAX_SOURCES_DEF       = 8;
   localparam int VALUE_HANDLE_BITS_DEF = 32;

   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int SOURCE_W = 3;
   localparam int COUNT_W  = 4;
   localparam int KIND_W   = 2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

   localparam logic OP_ENTRY  = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [KIND_W-1:0] KIND_WRITTEN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DUPLICATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISHED  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

endpackage

[sv/kway_merge_dedup.sv]
// Merges up to MAX_SOURCES ascending key streams into one ascending stream, marking
// repeated keys as duplicates (equal keys go to the lowest source). One head entry is kept per
// source; each request beat delivers the next entry of a source or marks it exhausted.
// Once every unfinished source below source_count holds a head, the smallest head is
// popped and its source is named in rsp_refill_source, so the producer knows which stream
// to advance. A request is taken every cycle unless req_stall is high (a resolved beat
// held up by a stalled result); a beat lands in an input register and is resolved from
// there against all heads at once (parallel pairwise key compares) into the result register.
// The result register lets the next request enter while a result waits. csr_ready is
// always high; source_count must only be written while the block is idle.
module kway_merge_dedup #(
   parameter int MAX_SOURCES       = kmd_pkg::MAX_SOURCES_DEF,
   parameter int VALUE_HANDLE_BITS = kmd_pkg::VALUE_HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [kmd_pkg::SOURCE_W-1:0]  req_source,
   input  logic [kmd_pkg::KEY_W-1:0]     req_entry_key,
   input  logic [kmd_pkg::VALUE_W-1:0]   req_value_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kmd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [kmd_pkg::KEY_W-1:0]     rsp_out_key,
   output logic [kmd_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic [kmd_pkg::SOURCE_W-1:0]  rsp_refill_source,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kmd_pkg::COUNT_W-1:0]   csr_source_count
);
   import kmd_pkg::*;

   localparam int IDX_W = $clog2(MAX_SOURCES);
   localparam int CNT_W = $clog2(MAX_SOURCES + 1);
   localparam int HB    = (VALUE_HANDLE_BITS < VALUE_W) ? VALUE_HANDLE_BITS : VALUE_W;

   // configuration
   logic [COUNT_W-1:0] source_count_ff, source_count_in;
   logic [CNT_W-1:0]   act_cnt;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_op_ff;
   logic [SOURCE_W-1:0] s1_source_ff;
   logic [KEY_W-1:0]    s1_key_ff;
   logic [HB-1:0]       s1_value_ff;
   logic                req_take;

   // merge state
   logic [MAX_SOURCES-1:0] head_valid_ff, head_valid_in;
   logic [MAX_SOURCES-1:0] fin_ff, fin_in;
   logic [KEY_W-1:0]       head_key_ff [MAX_SOURCES];
   logic [HB-1:0]          head_value_ff [MAX_SOURCES];
   logic [KEY_W-1:0]       written_key_ff, written_key_in;
   logic                   any_written_ff, any_written_in;
   logic                   head_we;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [SOURCE_W-1:0] rsp_refill_ff;

   // resolve logic
   logic                   out_free, s1_take;
   logic [IDX_W-1:0]       src_idx;
   logic                   err;
   logic [MAX_SOURCES-1:0] act, nv, nf, cand, win;
   logic [KEY_W-1:0]       nk [MAX_SOURCES];
   logic                   all_ready, any_head;
   logic [IDX_W-1:0]       best;
   logic [KEY_W-1:0]       best_key;
   logic [HB-1:0]          best_value;
   logic                   res_valid;
   logic [KIND_W-1:0]      res_kind;
   logic [KEY_W-1:0]       res_key;
   logic [VALUE_W-1:0]     res_value;
   logic [SOURCE_W-1:0]    res_refill;

   assign csr_ready       = 1'b1;
   assign source_count_in = (csr_valid && csr_ready) ? csr_source_count : source_count_ff;

   always_comb begin
      if (source_count_ff == '0) begin
         act_cnt = CNT_W'(1);
      end else if (32'(source_count_ff) > MAX_SOURCES) begin
         act_cnt = CNT_W'(MAX_SOURCES);
      end else begin
         act_cnt = CNT_W'(source_count_ff);
      end
   end

   // handshake
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_take     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_take ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);

   assign src_idx = IDX_W'(s1_source_ff);

   always_comb begin
      err = (32'(s1_source_ff) >= 32'(act_cnt)) || head_valid_ff[src_idx] || fin_ff[src_idx]
         || (s1_op_ff == OP_ENTRY && any_written_ff && s1_key_ff < written_key_ff);
      all_ready = 1'b1;
      for (int i = 0; i < MAX_SOURCES; i++) begin
         act[i]  = 32'(i) < 32'(act_cnt);
         nv[i]   = head_valid_ff[i] || (s1_op_ff == OP_ENTRY && src_idx == IDX_W'(i));
         nf[i]   = fin_ff[i] || (s1_op_ff == OP_FINISH && src_idx == IDX_W'(i));
         nk[i]   = (src_idx == IDX_W'(i)) ? s1_key_ff : head_key_ff[i];
         cand[i] = act[i] && nv[i];
         if (act[i] && !nv[i] && !nf[i]) begin
            all_ready = 1'b0;
         end
      end
      any_head = |cand;
      // a head wins if it beats every lower candidate strictly and ties no worse above
      for (int i = 0; i < MAX_SOURCES; i++) begin
         win[i] = cand[i];
         for (int j = 0; j < MAX_SOURCES; j++) begin
            if (j < i && cand[j]) begin
               win[i] = win[i] && (nk[i] < nk[j]);
            end else if (j > i && cand[j]) begin
               win[i] = win[i] && (nk[i] <= nk[j]);
            end
         end
      end
      best       = '0;
      best_key   = '0;
      best_value = '0;
      for (int i = 0; i < MAX_SOURCES; i++) begin
         if (win[i]) begin
            best       = best | IDX_W'(i);
            best_key   = best_key | nk[i];
            best_value = best_value | ((src_idx == IDX_W'(i)) ? s1_value_ff : head_value_ff[i]);
         end
      end
   end

   always_comb begin
      head_valid_in  = head_valid_ff;
      fin_in         = fin_ff;
      written_key_in = written_key_ff;
      any_written_in = any_written_ff;
      head_we        = 1'b0;
      res_valid      = 1'b0;
      res_kind       = KIND_ERROR;
      res_key        = '0;
      res_value      = '0;
      res_refill     = '0;
      if (s1_take) begin
         if (err) begin
            res_valid = 1'b1;
         end else begin
            head_valid_in = nv;
            fin_in        = nf;
            head_we       = (s1_op_ff == OP_ENTRY);
            if (all_ready && !any_head) begin
               // merge done, rearm
               head_valid_in  = '0;
               fin_in         = '0;
               written_key_in = '0;
               any_written_in = 1'b0;
               res_valid      = 1'b1;
               res_kind       = KIND_FINISHED;
            end else if (all_ready) begin
               head_valid_in[best] = 1'b0;
               res_valid           = 1'b1;
               res_key             = best_key;
               res_value           = VALUE_W'(best_value);
               res_refill          = SOURCE_W'(best);
               if (!any_written_ff || best_key != written_key_ff) begin
                  res_kind       = KIND_WRITTEN;
                  written_key_in = best_key;
                  any_written_in = 1'b1;
               end else begin
                  res_kind = KIND_DUPLICATE;
               end
            end
         end
      end
   end

   assign rsp_valid_in = out_free ? (s1_take && res_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_count_ff <= COUNT_RESET;
         s1_valid_ff     <= 1'b0;
         head_valid_ff   <= '0;
         fin_ff          <= '0;
         written_key_ff  <= '0;
         any_written_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         source_count_ff <= source_count_in;
         s1_valid_ff     <= s1_valid_in;
         head_valid_ff   <= head_valid_in;
         fin_ff          <= fin_in;
         written_key_ff  <= written_key_in;
         any_written_ff  <= any_written_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff     <= req_op;
         s1_source_ff <= req_source;
         s1_key_ff    <= req_entry_key;
         s1_value_ff  <= req_value_handle[HB-1:0];
      end
      if (head_we) begin
         head_key_ff[src_idx]   <= s1_key_ff;
         head_value_ff[src_idx] <= s1_value_ff;
      end
      if (s1_take && res_valid) begin
         rsp_kind_ff   <= res_kind;
         rsp_key_ff    <= res_key;
         rsp_value_ff  <= res_value;
         rsp_refill_ff <= res_refill;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_key       = rsp_key_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_refill_source = rsp_refill_ff;

endmodule

[sv/kmd_check.sv]
// port-level checks of the merge block and their bind
`include "kway_merge_dedup_assert.svh"

module kmd_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [kmd_pkg::KIND_W-1:0]    rsp_kind,
   input logic [kmd_pkg::KEY_W-1:0]     rsp_out_key,
   input logic [kmd_pkg::VALUE_W-1:0]   rsp_out_value,
   input logic [kmd_pkg::SOURCE_W-1:0]  rsp_refill_source
);
   import kmd_pkg::*;

   // a stalled result beat holds
   `KMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_key) && $stable(rsp_out_value) && $stable(rsp_refill_source))

   // finish and error beats carry no entry
   `KMD_ASSERT_IMP(a_no_pop_payload, clock, reset, rsp_valid && (rsp_kind == KIND_FINISHED || rsp_kind == KIND_ERROR), rsp_out_key == '0 && rsp_out_value == '0 && rsp_refill_source == '0)

   // back-pressure on requests only comes from a blocked result
   `KMD_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // nothing pending straight out of reset
   `KMD_ASSERT_IMP(a_reset_quiet, clock, reset, $fell(reset), !rsp_valid && !req_stall)

endmodule

bind kway_merge_dedup kmd_check u_kmd_check (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_out_key       (rsp_out_key),
   .rsp_out_value     (rsp_out_value),
   .rsp_refill_source (rsp_refill_source)
);
